// ----- rtl/sdm_pkg.sv -----
// Shared constants, tables and types of the spin drift motor mixer.
`timescale 1ns / 1ps
package sdm_pkg;

  // Fixed-point formats
  localparam int Q_ONE        = 16384;  // 1.0 in Q2.14
  localparam int AXIS_LIMIT   = 16711;  // 1.02 in Q2.14
  localparam int THR_DEAD     = 819;    // 0.05 in Q2.14
  localparam int AXIS_W       = 16;     // signed stick axis
  localparam int THR_W        = 15;     // throttle 0..16384
  localparam int MAG_W        = 15;     // stick magnitude
  localparam int LEVEL_W      = 17;     // low/high level 0..32768
  localparam int QUOT_W       = 16;     // scaler quotient bits
  localparam int AXIS_SHIFT   = 15;     // axis numerator scale 2^15
  localparam int THR_SHIFT    = 14;     // throttle numerator scale 2^14
  localparam int DRIVE_SHIFT  = 15;     // level units of 1/32768

  // Vector unit
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 16;
  localparam int XY_W         = 32;
  localparam int ACC_W        = 32;
  localparam int SQ_W         = 31;

  localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_MIN  = 3'd0,
    REG_LAT_MAX  = 3'd1,
    REG_FWD_MIN  = 3'd2,
    REG_FWD_MAX  = 3'd3,
    REG_THR_MIN  = 3'd4,
    REG_THR_MAX  = 3'd5,
    REG_SPIN_REV = 3'd6
  } cfg_reg_t;

  localparam int RST_LAT_MIN = 994;
  localparam int RST_LAT_MAX = 2014;
  localparam int RST_FWD_MIN = 990;
  localparam int RST_FWD_MAX = 2010;
  localparam int RST_THR_MIN = 1000;
  localparam int RST_THR_MAX = 2014;

  // Scaler status that travels with each quotient
  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_flags_t;

endpackage

// ----- rtl/sdm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for the pulse scalers.
`timescale 1ns / 1ps
module sdm_div #(
  parameter int PULSE_BITS = 12,
  parameter int SHIFT      = 15,
  parameter int SIDE_W     = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [PULSE_BITS-1:0]    in_num,
  input  logic [PULSE_BITS-1:0]    in_den,
  input  logic                     in_neg,
  input  logic                     in_zero,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [sdm_pkg::QUOT_W-1:0] out_quot,
  output sdm_pkg::div_flags_t      out_flags,
  output logic [SIDE_W-1:0]        out_side
);
  import sdm_pkg::*;

  localparam int NW = PULSE_BITS + SHIFT;
  localparam int CW = PULSE_BITS + QUOT_W + 1;

  logic                  v_r    [QUOT_W];
  logic [NW-1:0]         rem_r  [QUOT_W];
  logic [QUOT_W-1:0]     q_r    [QUOT_W];
  logic [PULSE_BITS-1:0] d_r    [QUOT_W];
  div_flags_t            f_r    [QUOT_W];
  logic [SIDE_W-1:0]     side_r [QUOT_W];

  logic [CW-1:0] num_ext;
  logic [CW-1:0] den_ext;
  logic          ovf0;

  // Flag a quotient that does not fit in QUOT_W bits
  assign num_ext = CW'({in_num, {SHIFT{1'b0}}});
  assign den_ext = CW'({in_den, {QUOT_W{1'b0}}});
  assign ovf0    = (num_ext >= den_ext);

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int K = QUOT_W - 1 - s;

    logic                  v_i;
    logic [NW-1:0]         rem_i;
    logic [QUOT_W-1:0]     q_i;
    logic [PULSE_BITS-1:0] d_i;
    div_flags_t            f_i;
    logic [SIDE_W-1:0]     side_i;
    logic [CW-1:0]         trial;
    logic [CW-1:0]         rem_x;
    logic                  ge;
    logic [QUOT_W-1:0]     q_nxt;
    logic [NW-1:0]         rem_nxt;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = {in_num, {SHIFT{1'b0}}};
      assign q_i    = '0;
      assign d_i    = in_den;
      assign f_i    = '{neg: in_neg, zero: in_zero, ovf: ovf0};
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign q_i    = q_r[s-1];
      assign d_i    = d_r[s-1];
      assign f_i    = f_r[s-1];
      assign side_i = side_r[s-1];
    end

    // Try to subtract the shifted divisor
    assign trial = CW'(d_i) << K;
    assign rem_x = CW'(rem_i);
    assign ge    = (rem_x >= trial);

    always_comb begin
      q_nxt    = q_i;
      q_nxt[K] = ge;
      rem_nxt  = ge ? NW'(rem_x - trial) : rem_i;
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    // Advance the payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        d_r[s]    <= d_i;
        f_r[s]    <= f_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid = v_r[QUOT_W-1];
  assign out_quot  = q_r[QUOT_W-1];
  assign out_flags = f_r[QUOT_W-1];
  assign out_side  = side_r[QUOT_W-1];

endmodule

// ----- rtl/sdm_polar.sv -----
// Pipelined CORDIC arctangent with a parallel integer square root of the stick vector.
`timescale 1ns / 1ps
module sdm_polar #(
  parameter int ANGLE_BITS = 16,
  parameter int SIDE_W     = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [sdm_pkg::AXIS_W-1:0] in_lat,
  input  logic signed [sdm_pkg::AXIS_W-1:0] in_fwd,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [ANGLE_BITS-1:0]             out_dir,
  output logic [sdm_pkg::MAG_W-1:0]         out_mag,
  output logic [SIDE_W-1:0]                 out_side
);
  import sdm_pkg::*;

  localparam int NS = CORDIC_STEPS + 1;

  logic                   v_r    [NS];
  logic signed [XY_W-1:0] x_r    [NS];
  logic signed [XY_W-1:0] y_r    [NS];
  logic [ACC_W-1:0]       acc_r  [NS];
  logic [SQ_W-1:0]        sv_r   [NS];
  logic [SQ_W-1:0]        sr_r   [NS];
  logic                   zero_r [NS];
  logic [SIDE_W-1:0]      side_r [NS];

  logic signed [XY_W-1:0] la;
  logic signed [XY_W-1:0] fa;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  logic [XY_W-1:0]        sq0;
  logic                   flip0;
  logic [ACC_W-1:0]       acc_rnd;

  // Scale the vector, fold into the right half plane, square the axes
  always_comb begin
    la    = XY_W'(in_lat);
    fa    = XY_W'(in_fwd);
    flip0 = in_fwd[AXIS_W-1];
    x0    = flip0 ? -(fa <<< 14) : (fa <<< 14);
    y0    = flip0 ? -(la <<< 14) : (la <<< 14);
    sq0   = XY_W'(la * la) + XY_W'(fa * fa);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      acc_r[0]  <= flip0 ? {1'b1, {(ACC_W-1){1'b0}}} : '0;
      sv_r[0]   <= SQ_W'(sq0);
      sr_r[0]   <= '0;
      zero_r[0] <= (in_lat == '0) && (in_fwd == '0);
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] x_nxt;
    logic signed [XY_W-1:0] y_nxt;
    logic [ACC_W-1:0]       acc_nxt;
    logic [SQ_W-1:0]        sv_nxt;
    logic [SQ_W-1:0]        sr_nxt;

    // Rotate toward the x axis
    always_comb begin
      xs = x_r[s] >>> s;
      ys = y_r[s] >>> s;
      if (y_r[s] > 0) begin
        x_nxt   = x_r[s] + ys;
        y_nxt   = y_r[s] - xs;
        acc_nxt = acc_r[s] + ATAN_TURNS[s];
      end else begin
        x_nxt   = x_r[s] - ys;
        y_nxt   = y_r[s] + xs;
        acc_nxt = acc_r[s] - ATAN_TURNS[s];
      end
    end

    // One square root step while the bit lasts, then hold the root
    if (s < SQRT_STEPS) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (30 - 2 * s);
      logic [SQ_W-1:0] sum;
      always_comb begin
        sum = sr_r[s] + BIT;
        if (sv_r[s] >= sum) begin
          sv_nxt = sv_r[s] - sum;
          sr_nxt = (sr_r[s] >> 1) + BIT;
        end else begin
          sv_nxt = sv_r[s];
          sr_nxt = sr_r[s] >> 1;
        end
      end
    end else begin : g_hold
      assign sv_nxt = sv_r[s];
      assign sr_nxt = sr_r[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s+1]    <= x_nxt;
        y_r[s+1]    <= y_nxt;
        acc_r[s+1]  <= acc_nxt;
        sv_r[s+1]   <= sv_nxt;
        sr_r[s+1]   <= sr_nxt;
        zero_r[s+1] <= zero_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  // Round the accumulated angle to the output width
  assign acc_rnd   = acc_r[NS-1] + (ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS));
  assign out_valid = v_r[NS-1];
  assign out_dir   = zero_r[NS-1] ? '0 : acc_rnd[ACC_W-1 -: ANGLE_BITS];
  assign out_mag   = sr_r[NS-1][MAG_W-1:0];
  assign out_side  = side_r[NS-1];

endmodule

// ----- rtl/sdm_mix.sv -----
// Magnitude limits, low/high drive levels, quarter-turn swap and drive scaling.
`timescale 1ns / 1ps
module sdm_mix #(
  parameter int ANGLE_BITS = 16,
  parameter int DRIVE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [sdm_pkg::MAG_W-1:0]  in_mag,
  input  logic [sdm_pkg::THR_W-1:0]  in_thr,
  input  logic [ANGLE_BITS-1:0]      in_dir,
  input  logic [ANGLE_BITS-1:0]      in_rotor,
  input  logic                       in_reversed,
  output logic                       out_valid,
  output logic [DRIVE_BITS-1:0]      out_first,
  output logic [DRIVE_BITS-1:0]      out_second
);
  import sdm_pkg::*;

  localparam int PROD_W = LEVEL_W + DRIVE_BITS;
  localparam logic [DRIVE_BITS-1:0] FULL = '1;

  logic                  s1_v_r, s2_v_r, s3_v_r;
  logic [LEVEL_W-1:0]    s1_first_r, s1_second_r;
  logic [PROD_W-1:0]     s2_first_r, s2_second_r;
  logic [DRIVE_BITS-1:0] s3_first_r, s3_second_r;

  logic [LEVEL_W-1:0]    thr2;
  logic [LEVEL_W-1:0]    room;
  logic [LEVEL_W-1:0]    mag;
  logic [LEVEL_W-1:0]    low;
  logic [LEVEL_W-1:0]    high;
  logic [ANGLE_BITS-1:0] diff;
  logic                  rotor_near;
  logic                  swap;

  // Cap the magnitude and form the two levels
  always_comb begin
    thr2 = LEVEL_W'(in_thr) << 1;
    room = LEVEL_W'(2 * Q_ONE) - thr2;
    mag  = LEVEL_W'(in_mag);
    if (mag > LEVEL_W'(Q_ONE)) begin
      mag = LEVEL_W'(Q_ONE);
    end
    if (mag > thr2) begin
      mag = thr2;
    end
    if (mag > room) begin
      mag = room;
    end
    low        = thr2 - mag;
    high       = thr2 + mag;
    diff       = in_dir - in_rotor;
    rotor_near = (diff[ANGLE_BITS-1] == diff[ANGLE_BITS-2]);
    swap       = !(rotor_near ^ in_reversed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Order the levels, scale to full drive, round
  always_ff @(posedge clk) begin
    if (en) begin
      s1_first_r  <= swap ? high : low;
      s1_second_r <= swap ? low : high;
      s2_first_r  <= PROD_W'(s1_first_r) * PROD_W'(FULL);
      s2_second_r <= PROD_W'(s1_second_r) * PROD_W'(FULL);
      s3_first_r  <= DRIVE_BITS'((s2_first_r + PROD_W'(Q_ONE)) >> DRIVE_SHIFT);
      s3_second_r <= DRIVE_BITS'((s2_second_r + PROD_W'(Q_ONE)) >> DRIVE_SHIFT);
    end
  end

  assign out_valid  = s3_v_r;
  assign out_first  = s3_first_r;
  assign out_second = s3_second_r;

endmodule

// ----- rtl/spin_drift_motor_mixer_top.sv -----
// Top level of the spin drift motor mixer: config registers, scaling, vector unit, output queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready): one transaction carries the lateral,
//   forward and throttle pulse widths and the rotor angle. Output channel
//   (out_valid/out_ready): one transaction per input with both motor drives.
//   Config port: write cfg_data to register cfg_index while cfg_write_en is
//   high; unknown indexes are ignored. Write only while the block is idle.
//   Pipeline: input register, scaler setup, 16 divider stages, clamp,
//   29 vector stages (28 CORDIC steps alongside the 16-step square root),
//   3 mix stages and the output register.
//   Throughput: one transaction per cycle while the output queue is not
//   full; every stage takes a new item each cycle, so the 28-stage CORDIC
//   sets only the latency.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the default
//   end points (994/2014, 990/2010, 1000/2014) and normal spin.
//   Receiver stall: a two-entry output queue takes the pipeline's results;
//   the whole pipeline holds and in_ready drops only when both entries are
//   full, and both resume in the cycle after the next output transaction.
module spin_drift_motor_mixer_top #(
  parameter int ANGLE_BITS = 16,
  parameter int PULSE_BITS = 12,
  parameter int DRIVE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PULSE_BITS-1:0]         in_lateral_pulse,
  input  logic [PULSE_BITS-1:0]         in_forward_pulse,
  input  logic [PULSE_BITS-1:0]         in_throttle_pulse,
  input  logic [ANGLE_BITS-1:0]         in_rotor_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DRIVE_BITS-1:0]         out_first_motor_drive,
  output logic [DRIVE_BITS-1:0]         out_second_motor_drive,
  input  logic                          cfg_write_en,
  input  logic [sdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_BITS-1:0]         cfg_data
);
  import sdm_pkg::*;

  localparam int SIDE_W = THR_W + ANGLE_BITS;

  typedef struct packed {
    logic [PULSE_BITS-1:0] num;
    logic [PULSE_BITS-1:0] den;
    logic                  neg;
    logic                  zero;
  } prep_t;

  // Magnitudes and sign of (p - lo) / (hi - lo)
  function automatic prep_t prep(input logic [PULSE_BITS-1:0] p,
                                 input logic [PULSE_BITS-1:0] lo,
                                 input logic [PULSE_BITS-1:0] hi);
    logic signed [PULSE_BITS:0] n;
    logic signed [PULSE_BITS:0] dn;
    prep_t r;
    n      = $signed({1'b0, p}) - $signed({1'b0, lo});
    dn     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    r.num  = n[PULSE_BITS] ? PULSE_BITS'(-n) : n[PULSE_BITS-1:0];
    r.den  = dn[PULSE_BITS] ? PULSE_BITS'(-dn) : dn[PULSE_BITS-1:0];
    r.neg  = n[PULSE_BITS] ^ dn[PULSE_BITS];
    r.zero = (dn == '0);
    return r;
  endfunction

  // Signed stick axis with the dead band beyond 1.02
  function automatic logic signed [AXIS_W-1:0] axis_post(input logic [QUOT_W-1:0] q,
                                                        input div_flags_t f);
    logic signed [QUOT_W+1:0] qs;
    logic signed [QUOT_W+1:0] ax;
    qs = f.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    ax = qs - (QUOT_W+2)'(Q_ONE);
    if (f.zero || f.ovf || ax > AXIS_LIMIT || ax < -AXIS_LIMIT) begin
      return '0;
    end
    return AXIS_W'(ax);
  endfunction

  // Throttle with dead zone and cap
  function automatic logic [THR_W-1:0] thr_post(input logic [QUOT_W-1:0] q,
                                                input div_flags_t f);
    logic signed [QUOT_W+1:0] qs;
    qs = f.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (f.zero) begin
      return '0;
    end
    if (f.ovf) begin
      return f.neg ? '0 : THR_W'(Q_ONE);
    end
    if (qs <= THR_DEAD) begin
      return '0;
    end
    if (qs > Q_ONE) begin
      return THR_W'(Q_ONE);
    end
    return THR_W'(qs);
  endfunction

  // Configuration registers
  logic [PULSE_BITS-1:0] lat_min_r, lat_max_r, fwd_min_r, fwd_max_r, thr_min_r, thr_max_r;
  logic                  spin_rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_min_r  <= PULSE_BITS'(RST_LAT_MIN);
      lat_max_r  <= PULSE_BITS'(RST_LAT_MAX);
      fwd_min_r  <= PULSE_BITS'(RST_FWD_MIN);
      fwd_max_r  <= PULSE_BITS'(RST_FWD_MAX);
      thr_min_r  <= PULSE_BITS'(RST_THR_MIN);
      thr_max_r  <= PULSE_BITS'(RST_THR_MAX);
      spin_rev_r <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LAT_MIN:  lat_min_r  <= cfg_data;
        REG_LAT_MAX:  lat_max_r  <= cfg_data;
        REG_FWD_MIN:  fwd_min_r  <= cfg_data;
        REG_FWD_MAX:  fwd_max_r  <= cfg_data;
        REG_THR_MIN:  thr_min_r  <= cfg_data;
        REG_THR_MAX:  thr_max_r  <= cfg_data;
        REG_SPIN_REV: spin_rev_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output queue is full
  logic [1:0] fifo_cnt_r;
  logic       en;

  assign en       = (fifo_cnt_r != 2'd2);
  assign in_ready = en;

  // Input register
  logic                  a_v_r;
  logic [PULSE_BITS-1:0] a_lat_r, a_fwd_r, a_thr_r;
  logic [ANGLE_BITS-1:0] a_rotor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lat_r   <= in_lateral_pulse;
      a_fwd_r   <= in_forward_pulse;
      a_thr_r   <= in_throttle_pulse;
      a_rotor_r <= in_rotor_angle;
    end
  end

  // Scaler setup
  logic                  b_v_r;
  prep_t                 b_lat_r, b_fwd_r, b_thr_r;
  logic [ANGLE_BITS-1:0] b_rotor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_lat_r   <= prep(a_lat_r, lat_min_r, lat_max_r);
      b_fwd_r   <= prep(a_fwd_r, fwd_min_r, fwd_max_r);
      b_thr_r   <= prep(a_thr_r, thr_min_r, thr_max_r);
      b_rotor_r <= a_rotor_r;
    end
  end

  // Dividers
  logic                  dl_v, df_v, dt_v;
  logic [QUOT_W-1:0]     dl_q, df_q, dt_q;
  div_flags_t            dl_f, df_f, dt_f;
  logic [ANGLE_BITS-1:0] dt_rotor;

  sdm_div #(.PULSE_BITS(PULSE_BITS), .SHIFT(AXIS_SHIFT), .SIDE_W(1)) u_div_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_r),
    .in_num(b_lat_r.num), .in_den(b_lat_r.den), .in_neg(b_lat_r.neg),
    .in_zero(b_lat_r.zero), .in_side(1'b0),
    .out_valid(dl_v), .out_quot(dl_q), .out_flags(dl_f), .out_side()
  );

  sdm_div #(.PULSE_BITS(PULSE_BITS), .SHIFT(AXIS_SHIFT), .SIDE_W(1)) u_div_fwd (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_r),
    .in_num(b_fwd_r.num), .in_den(b_fwd_r.den), .in_neg(b_fwd_r.neg),
    .in_zero(b_fwd_r.zero), .in_side(1'b0),
    .out_valid(df_v), .out_quot(df_q), .out_flags(df_f), .out_side()
  );

  sdm_div #(.PULSE_BITS(PULSE_BITS), .SHIFT(THR_SHIFT), .SIDE_W(ANGLE_BITS)) u_div_thr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v_r),
    .in_num(b_thr_r.num), .in_den(b_thr_r.den), .in_neg(b_thr_r.neg),
    .in_zero(b_thr_r.zero), .in_side(b_rotor_r),
    .out_valid(dt_v), .out_quot(dt_q), .out_flags(dt_f), .out_side(dt_rotor)
  );

  // Clamp the scaled values
  logic                     c_v_r;
  logic signed [AXIS_W-1:0] c_lat_r, c_fwd_r;
  logic [THR_W-1:0]         c_thr_r;
  logic [ANGLE_BITS-1:0]    c_rotor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= dl_v & df_v & dt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lat_r   <= axis_post(dl_q, dl_f);
      c_fwd_r   <= axis_post(df_q, df_f);
      c_thr_r   <= thr_post(dt_q, dt_f);
      c_rotor_r <= dt_rotor;
    end
  end

  // Direction and magnitude
  logic                  p_v;
  logic [ANGLE_BITS-1:0] p_dir;
  logic [MAG_W-1:0]      p_mag;
  logic [SIDE_W-1:0]     p_side;

  sdm_polar #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(SIDE_W)) u_polar (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_v_r),
    .in_lat(c_lat_r), .in_fwd(c_fwd_r), .in_side({c_thr_r, c_rotor_r}),
    .out_valid(p_v), .out_dir(p_dir), .out_mag(p_mag), .out_side(p_side)
  );

  // Drive levels
  logic                  m_v;
  logic [DRIVE_BITS-1:0] m_first, m_second;

  sdm_mix #(.ANGLE_BITS(ANGLE_BITS), .DRIVE_BITS(DRIVE_BITS)) u_mix (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p_v),
    .in_mag(p_mag), .in_thr(p_side[SIDE_W-1 -: THR_W]),
    .in_dir(p_dir), .in_rotor(p_side[ANGLE_BITS-1:0]),
    .in_reversed(spin_rev_r),
    .out_valid(m_v), .out_first(m_first), .out_second(m_second)
  );

  // Two-entry output queue: head drives the ports, skid catches one more
  logic [DRIVE_BITS-1:0] head_first_r, head_second_r;
  logic [DRIVE_BITS-1:0] skid_first_r, skid_second_r;
  logic [1:0]            fifo_cnt_nxt;
  logic                  push, pop;

  assign push = en && m_v;
  assign pop  = out_valid && out_ready;

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (push && !pop) begin
      fifo_cnt_nxt = fifo_cnt_r + 2'd1;
    end else if (pop && !push) begin
      fifo_cnt_nxt = fifo_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= 2'd0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (fifo_cnt_r == 2'd0 || (pop && fifo_cnt_r == 2'd1))) begin
      head_first_r  <= m_first;
      head_second_r <= m_second;
    end else if (pop && fifo_cnt_r == 2'd2) begin
      head_first_r  <= skid_first_r;
      head_second_r <= skid_second_r;
    end
    if (push && !pop && fifo_cnt_r == 2'd1) begin
      skid_first_r  <= m_first;
      skid_second_r <= m_second;
    end
  end

  assign out_valid              = (fifo_cnt_r != 2'd0);
  assign out_first_motor_drive  = head_first_r;
  assign out_second_motor_drive = head_second_r;

endmodule
